### rtl/quad_cascade_attitude_pid_mixer_assert.svh
// Assertion macros for the cascaded attitude controller.
`ifndef QUAD_CASCADE_ATTITUDE_PID_MIXER_ASSERT_SVH
`define QUAD_CASCADE_ATTITUDE_PID_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on the clock, skipped while reset is held.
`define QCAPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qcapm: assertion failed");
// Check a property on every clock edge, reset included.
`define QCAPM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("qcapm: assertion failed");
`else
`define QCAPM_ASSERT(lbl, clk, rst_n, prop)
`define QCAPM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### rtl/qcapm_pkg.sv
// Types, gains and sequencer codes shared by the attitude controller files.
`default_nettype none
package qcapm_pkg;

    // Input item of one control tick
    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [10:0]        stick_roll;
        logic [10:0]        stick_pitch;
        logic [10:0]        stick_yaw;
        logic [9:0]         throttle_ref;
    } t_in;

    // Result item: four motor compare values
    typedef struct packed {
        logic [9:0] motor_front_a;
        logic [9:0] motor_front_b;
        logic [9:0] motor_rear_a;
        logic [9:0] motor_rear_b;
    } t_out;

    // Multiplier constant width and Q16 gains
    localparam int KW = 23;
    localparam logic signed [KW-1:0] K_ANG_P   = 23'sd180224;
    localparam logic signed [KW-1:0] K_ANG_I   = 23'sd1638;
    localparam logic signed [KW-1:0] K_ANG_D   = 23'sd163840;
    localparam logic signed [KW-1:0] K_RP      = 23'sd163840;
    localparam logic signed [KW-1:0] K_YAW_P   = 23'sd393216;
    localparam logic signed [KW-1:0] K_YAW_D   = 23'sd360448;
    localparam logic signed [KW-1:0] K_RAD2DEG = 23'sd3754936;
    // ceil(2^24 / 10), for the smoothing divide
    localparam logic signed [KW-1:0] K_RECIP10 = 23'sd1677722;

    localparam int GAIN_SH  = 16;
    localparam int RECIP_SH = 24;

    // Stick centers
    localparam logic [10:0] CTR_ROLL  = 11'd993;
    localparam logic [10:0] CTR_PITCH = 11'd989;
    localparam logic [10:0] CTR_YAW   = 11'd996;

    // Product shift selection
    typedef enum logic [1:0] {
        SH_GAIN  = 2'd0,
        SH_RATE  = 2'd1,
        SH_RECIP = 2'd2
    } t_shift;

    // Where a registered product lands
    typedef enum logic [3:0] {
        DST_NONE   = 4'd0,
        DST_CR_LD  = 4'd1,
        DST_CR_ADD = 4'd2,
        DST_CP_LD  = 4'd3,
        DST_CP_ADD = 4'd4,
        DST_CP_SUB = 4'd5,
        DST_CY_LDN = 4'd6,
        DST_OR_LD  = 4'd7,
        DST_OR_ADD = 4'd8,
        DST_OP_LD  = 4'd9,
        DST_OP_ADD = 4'd10,
        DST_OY_LD  = 4'd11,
        DST_OY_ADD = 4'd12,
        DST_MOT    = 4'd13
    } t_dst;

    // Sequencer
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // Steps of one control tick
    localparam logic [4:0] OP_R_P  = 5'd0;
    localparam logic [4:0] OP_R_I  = 5'd1;
    localparam logic [4:0] OP_R_D  = 5'd2;
    localparam logic [4:0] OP_R_G  = 5'd3;
    localparam logic [4:0] OP_P_P  = 5'd4;
    localparam logic [4:0] OP_P_I  = 5'd5;
    localparam logic [4:0] OP_P_D  = 5'd6;
    localparam logic [4:0] OP_P_G  = 5'd7;
    localparam logic [4:0] OP_Y_G  = 5'd8;
    localparam logic [4:0] OP_IR_P = 5'd9;
    localparam logic [4:0] OP_IR_D = 5'd10;
    localparam logic [4:0] OP_IP_P = 5'd11;
    localparam logic [4:0] OP_IP_D = 5'd12;
    localparam logic [4:0] OP_IY_P = 5'd13;
    localparam logic [4:0] OP_IY_D = 5'd14;
    localparam logic [4:0] OP_SAVE = 5'd15;
    localparam logic [4:0] OP_M0   = 5'd16;
    localparam logic [4:0] OP_M1   = 5'd17;
    localparam logic [4:0] OP_M2   = 5'd18;
    localparam logic [4:0] OP_M3   = 5'd19;
    localparam logic [4:0] OP_END  = 5'd20;

    // Motor indexes
    localparam logic [1:0] MOT_FA = 2'd0;
    localparam logic [1:0] MOT_FB = 2'd1;
    localparam logic [1:0] MOT_RA = 2'd2;
    localparam logic [1:0] MOT_RB = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_STEP_LIM = 3'd0;
    localparam logic [2:0] REG_INT_LIM  = 3'd1;
    localparam logic [2:0] REG_IDLE_THR = 3'd2;
    localparam logic [2:0] REG_MOT_MIN  = 3'd3;
    localparam logic [2:0] REG_MOT_MAX  = 3'd4;

endpackage
`default_nettype wire

### rtl/qcapm_mul.sv
// Shared signed multiplier with selectable right shift and registered product.
`default_nettype none
module qcapm_mul #(
    parameter int AW      = 34,
    parameter int RATE_SH = 20
) (
    input  wire logic                            i_clk,
    input  wire logic signed [AW-1:0]            i_a,
    input  wire logic signed [qcapm_pkg::KW-1:0] i_k,
    input  wire qcapm_pkg::t_shift               i_sh,
    output logic signed [AW-1:0]                 o_p
);
    localparam int PW = AW + qcapm_pkg::KW;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shd;
    logic signed [AW-1:0] r_p;

    // Multiply at full width
    assign prod = PW'(i_a) * PW'(i_k);

    // Floor shift by the selected amount
    always_comb begin
        case (i_sh)
            qcapm_pkg::SH_GAIN:  shd = prod >>> qcapm_pkg::GAIN_SH;
            qcapm_pkg::SH_RATE:  shd = prod >>> RATE_SH;
            qcapm_pkg::SH_RECIP: shd = prod >>> qcapm_pkg::RECIP_SH;
            default:             shd = prod >>> qcapm_pkg::GAIN_SH;
        endcase
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        r_p <= shd[AW-1:0];
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

### rtl/quad_cascade_attitude_pid_mixer.sv
// Cascaded attitude PID controller with X-frame four-motor mixer.
//
// Input channel: i_valid / o_ready carry one control tick (angles, gyro rates,
// sticks, throttle) per transaction in i_cmd. Output channel: o_valid / i_ready
// carry the four motor commands in o_res.
// Every tick runs through one shared multiplier under a step sequencer: fifteen
// gain and rate products, then four smoothing divides by reciprocal. The result
// register then loads in ST_DONE, which also raises o_valid, and the sequencer
// returns to ST_IDLE, where the next tick is taken. A new tick is accepted only
// once the last one has left the sequencer.
// o_ready is high only while no tick is in work. A finished result waits in
// the output register; if the receiver stalls while a second result is done,
// the sequencer holds that result until the register frees.
// Reset (i_rst_n low, synchronous) clears the integrals, the previous errors,
// the remembered motor commands and restores the register defaults.
// APB writes are taken in the access phase; pready is always high.
`default_nettype none
`include "quad_cascade_attitude_pid_mixer_assert.svh"
module quad_cascade_attitude_pid_mixer #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire qcapm_pkg::t_in   i_cmd,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output qcapm_pkg::t_out       o_res,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [4:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int AW      = FRAC_BITS + 26;
    localparam int RATE_SH = 28 - FRAC_BITS;
    localparam int ASH_L   = (FRAC_BITS >= 7) ? FRAC_BITS - 7 : 0;
    localparam int ASH_R   = (FRAC_BITS >= 7) ? 0 : 7 - FRAC_BITS;

    // Configuration registers
    logic [6:0]  r_step_lim;
    logic [14:0] r_int_lim;
    logic [9:0]  r_idle_thr;
    logic [9:0]  r_mot_min;
    logic [9:0]  r_mot_max;

    // Sequencer
    qcapm_pkg::t_state r_state;
    logic [4:0]        r_step;
    qcapm_pkg::t_dst   r_dst;
    logic [1:0]        r_midx;

    // Tick operands
    qcapm_pkg::t_in       r_in;
    logic signed [AW-1:0] r_er;
    logic signed [AW-1:0] r_ep;
    logic signed [9:0]    r_yoff;
    logic                 r_idle;

    // Controller state
    logic signed [AW-1:0] r_integ_r;
    logic signed [AW-1:0] r_integ_p;
    logic signed [AW-1:0] r_prev_er;
    logic signed [AW-1:0] r_prev_ep;
    logic signed [AW-1:0] r_prev_cr;
    logic signed [AW-1:0] r_prev_cp;
    logic signed [AW-1:0] r_prev_cy;
    logic [9:0]           r_last [4];

    // Accumulators
    logic signed [AW-1:0] r_cr;
    logic signed [AW-1:0] r_cp;
    logic signed [AW-1:0] r_cy;
    logic signed [AW-1:0] r_or;
    logic signed [AW-1:0] r_op;
    logic signed [AW-1:0] r_oy;
    logic signed [19:0]   r_v;

    // Output register
    logic            r_ovalid;
    qcapm_pkg::t_out r_out;

    // Combinational nets
    logic                 accept;
    logic signed [AW-1:0] ld_er;
    logic signed [AW-1:0] ld_ep;
    logic signed [AW-1:0] step_lim_q;
    logic signed [AW-1:0] int_lim_q;
    logic signed [AW-1:0] n_integ_r;
    logic signed [AW-1:0] n_integ_p;
    logic signed [AW-1:0] mul_a;
    logic signed [qcapm_pkg::KW-1:0] mul_k;
    qcapm_pkg::t_shift    mul_sh;
    qcapm_pkg::t_dst      n_dst;
    logic signed [AW-1:0] prod;
    logic [1:0]           iss_idx;
    logic signed [AW-1:0] thr_q;
    logic signed [AW-1:0] mix;
    logic signed [AW-1:0] mix_w;
    logic signed [15:0]   mix_s;
    logic signed [19:0]   last_x;
    logic signed [19:0]   n_v;
    logic signed [19:0]   q0;
    logic signed [19:0]   rem;
    logic signed [19:0]   q1;
    logic signed [19:0]   q2;

    // Truncated divide of a stick offset by six, through a reciprocal
    function automatic logic signed [8:0] f_div6(input logic [10:0] s, input logic [10:0] c);
        logic signed [11:0] d;
        logic [10:0]        m;
        logic [24:0]        pr;
        logic signed [8:0]  q;
        d  = $signed({1'b0, s}) - $signed({1'b0, c});
        m  = d[11] ? 11'(-d) : d[10:0];
        pr = m * 14'd10923;
        q  = $signed({1'b0, pr[23:16]});
        return d[11] ? -q : q;
    endfunction

    // Truncated divide of a stick offset by four
    function automatic logic signed [9:0] f_div4(input logic [10:0] s, input logic [10:0] c);
        logic signed [11:0] d;
        logic [10:0]        m;
        logic signed [9:0]  q;
        d = $signed({1'b0, s}) - $signed({1'b0, c});
        m = d[11] ? 11'(-d) : d[10:0];
        q = $signed({1'b0, m[10:2]});
        return d[11] ? -q : q;
    endfunction

    // Rescale a Q7 angle to the internal format
    function automatic logic signed [AW-1:0] f_angle(input logic signed [15:0] a);
        logic signed [AW-1:0] w;
        w = AW'(a);
        return (w <<< ASH_L) >>> ASH_R;
    endfunction

    // Symmetric clamp
    function automatic logic signed [AW-1:0] f_clamp(input logic signed [AW-1:0] v,
                                                     input logic signed [AW-1:0] lim);
        logic signed [AW-1:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == qcapm_pkg::ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_res   = r_out;
    assign pready  = 1'b1;

    // Angle errors from stick and measured angle
    assign ld_er = (AW'(f_div6(i_cmd.stick_roll, qcapm_pkg::CTR_ROLL)) <<< FRAC_BITS)
                 + f_angle(i_cmd.roll_angle);
    assign ld_ep = (AW'(f_div6(i_cmd.stick_pitch, qcapm_pkg::CTR_PITCH)) <<< FRAC_BITS)
                 + f_angle(i_cmd.pitch_angle);

    // Integral update: clamp the step, clamp the sum, clear at idle throttle
    assign step_lim_q = AW'($signed({1'b0, r_step_lim})) <<< FRAC_BITS;
    assign int_lim_q  = AW'($signed({1'b0, r_int_lim})) <<< FRAC_BITS;
    assign n_integ_r  = r_idle ? '0 :
                        f_clamp(r_integ_r + f_clamp(r_er, step_lim_q), int_lim_q);
    assign n_integ_p  = r_idle ? '0 :
                        f_clamp(r_integ_p + f_clamp(r_ep, step_lim_q), int_lim_q);

    // Motor mix, saturate and smoothing numerator
    assign iss_idx = r_step[1:0];
    assign thr_q   = AW'($signed({1'b0, r_in.throttle_ref})) <<< FRAC_BITS;
    always_comb begin
        case (iss_idx)
            qcapm_pkg::MOT_FA: mix = thr_q + r_or - r_op + r_oy;
            qcapm_pkg::MOT_FB: mix = thr_q - r_or - r_op - r_oy;
            qcapm_pkg::MOT_RA: mix = thr_q + r_or + r_op - r_oy;
            qcapm_pkg::MOT_RB: mix = thr_q - r_or + r_op + r_oy;
            default:           mix = thr_q;
        endcase
        mix_w = mix >>> FRAC_BITS;
        if (mix_w > AW'(32767)) begin
            mix_s = 16'sd32767;
        end else if (mix_w < -AW'(32768)) begin
            mix_s = -16'sd32768;
        end else begin
            mix_s = mix_w[15:0];
        end
        last_x = $signed({10'b0, r_last[iss_idx]});
        n_v    = (last_x <<< 1) + last_x + (20'(mix_s) <<< 3) - 20'(mix_s);
    end

    // Step table: multiplier operands and product destination
    always_comb begin
        mul_a  = '0;
        mul_k  = qcapm_pkg::K_RECIP10;
        mul_sh = qcapm_pkg::SH_GAIN;
        n_dst  = qcapm_pkg::DST_NONE;
        case (r_step)
            qcapm_pkg::OP_R_P: begin
                mul_a = r_er;            mul_k = qcapm_pkg::K_ANG_P;
                n_dst = qcapm_pkg::DST_CR_LD;
            end
            qcapm_pkg::OP_R_I: begin
                mul_a = r_integ_r;       mul_k = qcapm_pkg::K_ANG_I;
                n_dst = qcapm_pkg::DST_CR_ADD;
            end
            qcapm_pkg::OP_R_D: begin
                mul_a = r_er - r_prev_er; mul_k = qcapm_pkg::K_ANG_D;
                n_dst = qcapm_pkg::DST_CR_ADD;
            end
            qcapm_pkg::OP_R_G: begin
                mul_a  = AW'(r_in.gyro_y); mul_k = qcapm_pkg::K_RAD2DEG;
                mul_sh = qcapm_pkg::SH_RATE;
                n_dst  = qcapm_pkg::DST_CR_ADD;
            end
            qcapm_pkg::OP_P_P: begin
                mul_a = r_ep;            mul_k = qcapm_pkg::K_ANG_P;
                n_dst = qcapm_pkg::DST_CP_LD;
            end
            qcapm_pkg::OP_P_I: begin
                mul_a = r_integ_p;       mul_k = qcapm_pkg::K_ANG_I;
                n_dst = qcapm_pkg::DST_CP_ADD;
            end
            qcapm_pkg::OP_P_D: begin
                mul_a = r_ep - r_prev_ep; mul_k = qcapm_pkg::K_ANG_D;
                n_dst = qcapm_pkg::DST_CP_ADD;
            end
            qcapm_pkg::OP_P_G: begin
                mul_a  = AW'(r_in.gyro_x); mul_k = qcapm_pkg::K_RAD2DEG;
                mul_sh = qcapm_pkg::SH_RATE;
                n_dst  = qcapm_pkg::DST_CP_SUB;
            end
            qcapm_pkg::OP_Y_G: begin
                mul_a  = AW'(r_in.gyro_z); mul_k = qcapm_pkg::K_RAD2DEG;
                mul_sh = qcapm_pkg::SH_RATE;
                n_dst  = qcapm_pkg::DST_CY_LDN;
            end
            qcapm_pkg::OP_IR_P: begin
                mul_a = r_cr;            mul_k = qcapm_pkg::K_RP;
                n_dst = qcapm_pkg::DST_OR_LD;
            end
            qcapm_pkg::OP_IR_D: begin
                mul_a = r_cr - r_prev_cr; mul_k = qcapm_pkg::K_RP;
                n_dst = qcapm_pkg::DST_OR_ADD;
            end
            qcapm_pkg::OP_IP_P: begin
                mul_a = r_cp;            mul_k = qcapm_pkg::K_RP;
                n_dst = qcapm_pkg::DST_OP_LD;
            end
            qcapm_pkg::OP_IP_D: begin
                mul_a = r_cp - r_prev_cp; mul_k = qcapm_pkg::K_RP;
                n_dst = qcapm_pkg::DST_OP_ADD;
            end
            qcapm_pkg::OP_IY_P: begin
                mul_a = r_cy;            mul_k = qcapm_pkg::K_YAW_P;
                n_dst = qcapm_pkg::DST_OY_LD;
            end
            qcapm_pkg::OP_IY_D: begin
                mul_a = r_cy - r_prev_cy; mul_k = qcapm_pkg::K_YAW_D;
                n_dst = qcapm_pkg::DST_OY_ADD;
            end
            qcapm_pkg::OP_M0, qcapm_pkg::OP_M1, qcapm_pkg::OP_M2, qcapm_pkg::OP_M3: begin
                mul_a  = AW'(n_v);       mul_k = qcapm_pkg::K_RECIP10;
                mul_sh = qcapm_pkg::SH_RECIP;
                n_dst  = qcapm_pkg::DST_MOT;
            end
            default: begin
                n_dst = qcapm_pkg::DST_NONE;
            end
        endcase
        if (r_state != qcapm_pkg::ST_RUN) begin
            n_dst = qcapm_pkg::DST_NONE;
        end
    end

    qcapm_mul #(
        .AW      (AW),
        .RATE_SH (RATE_SH)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_k   (mul_k),
        .i_sh  (mul_sh),
        .o_p   (prod)
    );

    // Correct the reciprocal quotient to a floor, then clamp max before min
    always_comb begin
        q0  = prod[19:0];
        rem = r_v - (q0 <<< 3) - (q0 <<< 1);
        if (rem < 20'sd0) begin
            q1 = q0 - 20'sd1;
        end else if (rem >= 20'sd10) begin
            q1 = q0 + 20'sd1;
        end else begin
            q1 = q0;
        end
        q2 = q1;
        if (q2 > $signed({10'b0, r_mot_max})) begin
            q2 = $signed({10'b0, r_mot_max});
        end
        if (q2 < $signed({10'b0, r_mot_min})) begin
            q2 = $signed({10'b0, r_mot_min});
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_lim <= 7'd15;
            r_int_lim  <= 15'd4000;
            r_idle_thr <= 10'd100;
            r_mot_min  <= 10'd50;
            r_mot_max  <= 10'd985;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                qcapm_pkg::REG_STEP_LIM: r_step_lim <= pwdata[6:0];
                qcapm_pkg::REG_INT_LIM:  r_int_lim  <= pwdata[14:0];
                qcapm_pkg::REG_IDLE_THR: r_idle_thr <= pwdata[9:0];
                qcapm_pkg::REG_MOT_MIN:  r_mot_min  <= pwdata[9:0];
                qcapm_pkg::REG_MOT_MAX:  r_mot_max  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        case (paddr[4:2])
            qcapm_pkg::REG_STEP_LIM: prdata = 32'(r_step_lim);
            qcapm_pkg::REG_INT_LIM:  prdata = 32'(r_int_lim);
            qcapm_pkg::REG_IDLE_THR: prdata = 32'(r_idle_thr);
            qcapm_pkg::REG_MOT_MIN:  prdata = 32'(r_mot_min);
            qcapm_pkg::REG_MOT_MAX:  prdata = 32'(r_mot_max);
            default:                 prdata = '0;
        endcase
    end

    // Sequencer, controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= qcapm_pkg::ST_IDLE;
            r_step    <= qcapm_pkg::OP_R_P;
            r_dst     <= qcapm_pkg::DST_NONE;
            r_ovalid  <= 1'b0;
            r_integ_r <= '0;
            r_integ_p <= '0;
            r_prev_er <= '0;
            r_prev_ep <= '0;
            r_prev_cr <= '0;
            r_prev_cp <= '0;
            r_prev_cy <= '0;
            for (int i = 0; i < 4; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            r_dst <= n_dst;
            // Drop a taken result
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                qcapm_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_state <= qcapm_pkg::ST_RUN;
                        r_step  <= qcapm_pkg::OP_R_P;
                    end
                end
                qcapm_pkg::ST_RUN: begin
                    if (r_step == qcapm_pkg::OP_END) begin
                        r_state <= qcapm_pkg::ST_DONE;
                    end else begin
                        r_step <= r_step + 5'd1;
                    end
                    if (r_step == qcapm_pkg::OP_R_P) begin
                        r_integ_r <= n_integ_r;
                        r_integ_p <= n_integ_p;
                    end
                    if (r_step == qcapm_pkg::OP_SAVE) begin
                        r_prev_er <= r_er;
                        r_prev_ep <= r_ep;
                        r_prev_cr <= r_cr;
                        r_prev_cp <= r_cp;
                        r_prev_cy <= r_cy;
                    end
                end
                qcapm_pkg::ST_DONE: begin
                    // Hold until the output register frees
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= qcapm_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= qcapm_pkg::ST_IDLE;
                end
            endcase
            // Remember each finished motor command
            if (r_dst == qcapm_pkg::DST_MOT) begin
                r_last[r_midx] <= q2[9:0];
            end
        end
    end

    // Operand capture, accumulation and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in   <= i_cmd;
            r_er   <= ld_er;
            r_ep   <= ld_ep;
            r_yoff <= f_div4(i_cmd.stick_yaw, qcapm_pkg::CTR_YAW);
            r_idle <= (i_cmd.throttle_ref < r_idle_thr);
        end
        if (n_dst == qcapm_pkg::DST_MOT) begin
            r_v    <= n_v;
            r_midx <= iss_idx;
        end
        case (r_dst)
            qcapm_pkg::DST_CR_LD:  r_cr <= prod;
            qcapm_pkg::DST_CR_ADD: r_cr <= r_cr + prod;
            qcapm_pkg::DST_CP_LD:  r_cp <= prod;
            qcapm_pkg::DST_CP_ADD: r_cp <= r_cp + prod;
            qcapm_pkg::DST_CP_SUB: r_cp <= r_cp - prod;
            qcapm_pkg::DST_CY_LDN: r_cy <= -prod - (AW'(r_yoff) <<< FRAC_BITS);
            qcapm_pkg::DST_OR_LD:  r_or <= prod;
            qcapm_pkg::DST_OR_ADD: r_or <= r_or + prod;
            qcapm_pkg::DST_OP_LD:  r_op <= prod;
            qcapm_pkg::DST_OP_ADD: r_op <= r_op + prod;
            qcapm_pkg::DST_OY_LD:  r_oy <= prod;
            qcapm_pkg::DST_OY_ADD: r_oy <= r_oy + prod;
            default: ;
        endcase
        if (r_state == qcapm_pkg::ST_DONE && (!r_ovalid || i_ready)) begin
            r_out.motor_front_a <= r_last[qcapm_pkg::MOT_FA];
            r_out.motor_front_b <= r_last[qcapm_pkg::MOT_FB];
            r_out.motor_rear_a  <= r_last[qcapm_pkg::MOT_RA];
            r_out.motor_rear_b  <= r_last[qcapm_pkg::MOT_RB];
        end
    end

    // Sequencer checks
    `QCAPM_ASSERT(a_accept_starts, i_clk, i_rst_n, accept |=> (r_state == qcapm_pkg::ST_RUN && r_step == qcapm_pkg::OP_R_P))
    `QCAPM_ASSERT(a_step_bound, i_clk, i_rst_n, (r_state == qcapm_pkg::ST_RUN) |-> (r_step <= qcapm_pkg::OP_END))
    `QCAPM_ASSERT(a_end_leaves, i_clk, i_rst_n, (r_state == qcapm_pkg::ST_RUN && r_step == qcapm_pkg::OP_END) |=> (r_state == qcapm_pkg::ST_DONE))
    `QCAPM_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(o_valid) |-> ($past(r_state) == qcapm_pkg::ST_DONE))
endmodule
`default_nettype wire

### tb/tb_motor_checker.sv
// Checker for the attitude controller: predicts the four motor commands and compares.
module tb_motor_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_ready,
    input  qcapm_pkg::t_in        i_cmd,
    input  logic                  o_valid,
    input  logic                  i_ready,
    input  qcapm_pkg::t_out       o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output int                    o_fail_cnt,
    output int                    o_pending,
    output int                    o_ticks_seen,
    output int                    o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 8;

    longint step_lim, int_lim, idle_thr, mot_min, mot_max;
    longint roll_int, pitch_int, roll_err_q, pitch_err_q;
    longint roll_rate_q, pitch_rate_q, yaw_rate_q;
    longint last_cmd [4];
    qcapm_pkg::t_out motor_queue [$];

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint gain_mul(longint v, longint k);
        return (v * k) >>> 16;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint deg_rate(logic signed [15:0] g);
        longint gv;
        gv = g;
        return floor_shr(gv * 3754936, 28 - FB);
    endfunction

    // Outer PI-D for one axis; updates integral and previous error
    function automatic longint angle_pid(longint err, ref longint integ, ref longint prev,
                                         input bit idle);
        longint o;
        integ = clamp_sym(integ + clamp_sym(err, step_lim << FB), int_lim << FB);
        if (idle) integ = 0;
        o = gain_mul(err, qcapm_pkg::K_ANG_P) + gain_mul(integ, qcapm_pkg::K_ANG_I)
          + gain_mul(err - prev, qcapm_pkg::K_ANG_D);
        prev = err;
        return o;
    endfunction

    // Convert, smooth and clamp one motor
    function automatic logic [9:0] smooth_motor(longint mix, int idx);
        longint m, num, s;
        m = floor_shr(mix, FB);
        if (m > 32767) m = 32767;
        if (m < -32768) m = -32768;
        num = 3 * last_cmd[idx] + 7 * m;
        s = num / 10;
        if (num % 10 != 0 && num < 0) s--;
        if (s > mot_max) s = mot_max;
        if (s < mot_min) s = mot_min;
        s = s & 10'h3FF;
        last_cmd[idx] = s;
        return s[9:0];
    endfunction

    function automatic qcapm_pkg::t_out predict_motors(qcapm_pkg::t_in c);
        longint er, ep, ro, po, cr, cp, cy, orr, op, oy, t;
        longint sr, sp, sy, ra, pa;
        bit idle;
        qcapm_pkg::t_out r;
        sr = c.stick_roll;
        sp = c.stick_pitch;
        sy = c.stick_yaw;
        ra = c.roll_angle;
        pa = c.pitch_angle;
        idle = longint'(c.throttle_ref) < idle_thr;
        er = ((sr - 993) / 6) * (1 << FB) + ra * (1 << (FB - 7));
        ep = ((sp - 989) / 6) * (1 << FB) + pa * (1 << (FB - 7));
        ro = angle_pid(er, roll_int, roll_err_q, idle);
        po = angle_pid(ep, pitch_int, pitch_err_q, idle);
        cr = ro + deg_rate(c.gyro_y);
        cp = po - deg_rate(c.gyro_x);
        cy = -deg_rate(c.gyro_z) - ((sy - 996) / 4) * (1 << FB);
        orr = gain_mul(cr, qcapm_pkg::K_RP) + gain_mul(cr - roll_rate_q, qcapm_pkg::K_RP);
        op = gain_mul(cp, qcapm_pkg::K_RP) + gain_mul(cp - pitch_rate_q, qcapm_pkg::K_RP);
        oy = gain_mul(cy, qcapm_pkg::K_YAW_P) + gain_mul(cy - yaw_rate_q, qcapm_pkg::K_YAW_D);
        roll_rate_q = cr;
        pitch_rate_q = cp;
        yaw_rate_q = cy;
        t = longint'(c.throttle_ref) << FB;
        r.motor_front_a = smooth_motor(t + orr - op + oy, 0);
        r.motor_front_b = smooth_motor(t - orr - op - oy, 1);
        r.motor_rear_a  = smooth_motor(t + orr + op - oy, 2);
        r.motor_rear_b  = smooth_motor(t - orr + op + oy, 3);
        return r;
    endfunction

    task automatic check_field(string name, logic [9:0] exp_v, logic [9:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_cnt++;
        end
    endtask

    // Track config writes, predict on accepted ticks, compare on results
    always @(posedge i_clk) begin
        qcapm_pkg::t_out e;
        if (!i_rst_n) begin
            step_lim <= 15; int_lim <= 4000; idle_thr <= 100;
            mot_min <= 50; mot_max <= 985;
            roll_int = 0; pitch_int = 0; roll_err_q = 0; pitch_err_q = 0;
            roll_rate_q = 0; pitch_rate_q = 0; yaw_rate_q = 0;
            foreach (last_cmd[k]) last_cmd[k] = 0;
            motor_queue.delete();
            o_fail_cnt = 0; o_ticks_seen = 0; o_results_seen = 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    qcapm_pkg::REG_STEP_LIM: step_lim <= pwdata & 32'h7F;
                    qcapm_pkg::REG_INT_LIM:  int_lim  <= pwdata & 32'h7FFF;
                    qcapm_pkg::REG_IDLE_THR: idle_thr <= pwdata & 32'h3FF;
                    qcapm_pkg::REG_MOT_MIN:  mot_min  <= pwdata & 32'h3FF;
                    qcapm_pkg::REG_MOT_MAX:  mot_max  <= pwdata & 32'h3FF;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                motor_queue.push_back(predict_motors(i_cmd));
                o_ticks_seen++;
            end
            if (o_valid && i_ready) begin
                o_results_seen++;
                if (motor_queue.size() == 0) begin
                    $error("result with no tick outstanding");
                    o_fail_cnt++;
                end else begin
                    e = motor_queue.pop_front();
                    check_field("motor_front_a", e.motor_front_a, o_res.motor_front_a);
                    check_field("motor_front_b", e.motor_front_b, o_res.motor_front_b);
                    check_field("motor_rear_a", e.motor_rear_a, o_res.motor_rear_a);
                    check_field("motor_rear_b", e.motor_rear_b, o_res.motor_rear_b);
                end
            end
        end
        o_pending = motor_queue.size();
    end
endmodule

### tb/tb.sv
// Testbench top for the attitude controller: stimulus, register setup and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 5000;
    localparam int INW = $bits(qcapm_pkg::t_in);
    // Index with no register behind it
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            i_valid = 0;
    logic            o_ready;
    qcapm_pkg::t_in  i_cmd = '0;
    logic            o_valid;
    logic            i_ready = 0;
    qcapm_pkg::t_out o_res;
    logic            psel = 0, penable = 0, pwrite = 0;
    logic [4:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;
    int              fail_cnt, pending, ticks_seen, results_seen;
    int              idle_cycles = 0;
    bit              stall_mode = 0;

    always #1 i_clk = ~i_clk;

    quad_cascade_attitude_pid_mixer dut (.*);

    tb_motor_checker chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd, .o_valid, .i_ready, .o_res,
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .o_fail_cnt(fail_cnt), .o_pending(pending),
        .o_ticks_seen(ticks_seen), .o_results_seen(results_seen)
    );

    // Receiver stalls: random phases of heavy stalling and of none
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        i_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Watchdog: count cycles with no transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_tick(qcapm_pkg::t_in c);
        i_valid <= 1;
        i_cmd <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic qcapm_pkg::t_in rand_tick(bit calm);
        qcapm_pkg::t_in c;
        c = INW'({$urandom, $urandom, $urandom, $urandom});
        if (calm) begin
            c.roll_angle = 16'($urandom_range(0, 8000) - 4000);
            c.pitch_angle = 16'($urandom_range(0, 8000) - 4000);
            c.gyro_x = 16'($urandom_range(0, 4000) - 2000);
            c.gyro_y = 16'($urandom_range(0, 4000) - 2000);
            c.gyro_z = 16'($urandom_range(0, 4000) - 2000);
            c.stick_roll = 11'($urandom_range(900, 1100));
            c.stick_pitch = 11'($urandom_range(900, 1100));
            c.stick_yaw = 11'($urandom_range(900, 1100));
        end
        c.throttle_ref = ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                     : 10'($urandom_range(0, 1000));
        return c;
    endfunction

    initial begin
        qcapm_pkg::t_in c;
        int burst;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: extremes, stick centers, idle throttle edge
        for (int k = 0; k < 20; k++) begin
            c = '0;
            case (k % 5)
                0: c = {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                        11'h7FF, 11'h7FF, 11'h7FF, 10'd1000};
                1: c = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        11'h0, 11'h0, 11'h0, 10'd0};
                2: c = {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                        qcapm_pkg::CTR_ROLL, qcapm_pkg::CTR_PITCH, qcapm_pkg::CTR_YAW,
                        10'd99};
                3: c = {16'sd200, -16'sd200, 16'sd5, -16'sd5, 16'sd1,
                        11'd998, 11'd984, 11'd999, 10'd100};
                default: c = INW'({$urandom, $urandom, $urandom, $urandom});
            endcase
            if (k >= 10) c.throttle_ref = 10'h3FF;
            send_tick(c);
        end
        drain();

        // Random phases through several register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin reg_write(qcapm_pkg::REG_STEP_LIM, 0);
                       reg_write(qcapm_pkg::REG_INT_LIM, 0);
                       reg_write(qcapm_pkg::REG_IDLE_THR, 0);
                       reg_write(qcapm_pkg::REG_MOT_MIN, 0);
                       reg_write(qcapm_pkg::REG_MOT_MAX, 1023); end
                1: begin reg_write(qcapm_pkg::REG_STEP_LIM, 127);
                       reg_write(qcapm_pkg::REG_INT_LIM, 32767);
                       reg_write(qcapm_pkg::REG_IDLE_THR, 1023);
                       reg_write(qcapm_pkg::REG_MOT_MIN, 1023);
                       reg_write(qcapm_pkg::REG_MOT_MAX, 0); end
                2: begin reg_write(qcapm_pkg::REG_STEP_LIM, 90);
                       reg_write(qcapm_pkg::REG_INT_LIM, 50);
                       reg_write(qcapm_pkg::REG_IDLE_THR, 300);
                       reg_write(qcapm_pkg::REG_MOT_MIN, 50);
                       reg_write(qcapm_pkg::REG_MOT_MAX, 985); end
                3: begin reg_write(qcapm_pkg::REG_STEP_LIM, 2);
                       reg_write(qcapm_pkg::REG_INT_LIM, 20000);
                       reg_write(qcapm_pkg::REG_IDLE_THR, 10);
                       reg_write(REG_UNUSED, 32'hFFFF); end
                4: begin reg_write(qcapm_pkg::REG_STEP_LIM, $urandom);
                       reg_write(qcapm_pkg::REG_INT_LIM, $urandom);
                       reg_write(qcapm_pkg::REG_IDLE_THR, $urandom);
                       reg_write(qcapm_pkg::REG_MOT_MIN, $urandom);
                       reg_write(qcapm_pkg::REG_MOT_MAX, $urandom); end
                default: begin reg_write(qcapm_pkg::REG_STEP_LIM, 15);
                       reg_write(qcapm_pkg::REG_INT_LIM, 4000);
                       reg_write(qcapm_pkg::REG_IDLE_THR, 100);
                       reg_write(qcapm_pkg::REG_MOT_MIN, 50);
                       reg_write(qcapm_pkg::REG_MOT_MAX, 985); end
            endcase
            for (int n = 0; n < 150; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 150; b++, n++)
                    send_tick(rand_tick($urandom_range(0, 3) != 0));
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 0;
                    repeat ($urandom_range(1, 40)) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("tb: %0d ticks sent, %0d motor results checked over 7 register settings",
                 ticks_seen, results_seen);
        if (fail_cnt == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule
